/* hw/rtl/rrbmc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrbmc_pkg
// Shared constants, codes and types of the receive ring buffer with message
// counting.
// ----------------------------------------------------------------------------
package rrbmc_pkg;

   localparam int BUFFER_DEPTH = 64;
   localparam int IDX_W        = $clog2(BUFFER_DEPTH);
   localparam int BYTE_W       = 8;
   localparam int CNT_W        = 6;
   localparam int OP_W         = 2;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 8;

   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(BUFFER_DEPTH - 1);
   localparam logic [IDX_W-1:0] FULL_FILL = IDX_W'(BUFFER_DEPTH - 1);
   localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(63);
   localparam logic [CNT_W-1:0] DRAIN_END = CNT_W'(62);

   localparam logic [CSR_IDX_W-1:0] CSR_TERM_ENABLE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_CHAR   = CSR_IDX_W'(1);

   typedef enum logic [OP_W-1:0] {
      OP_RECEIVE      = 2'd0,
      OP_READ_BYTE    = 2'd1,
      OP_READ_MESSAGE = 2'd2
   } op_type;

   typedef struct packed {
      logic              strobe;
      logic [BYTE_W-1:0] data_byte;
      logic              data_valid;
      logic              last;
      logic [CNT_W-1:0]  bytes_available;
      logic [CNT_W-1:0]  messages_available;
      logic              overflow;
   } rsp_type;

   // low bits of the fill level as reported on a result
   function automatic logic [CNT_W-1:0] fill_report(input logic [IDX_W-1:0] fill);
      logic [IDX_W+CNT_W-1:0] wide;
      wide = {{CNT_W{1'b0}}, fill};
      return wide[CNT_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] nxt;
      nxt = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
      return nxt;
   endfunction

endpackage

/* hw/rtl/rrbmc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrbmc_ram
// Generic simple dual-port RAM: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module rrbmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/rrbmc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrbmc_ctrl
// Ring pointers, fill level, message count and the pop/drain sequencer
// around the byte store.
// ----------------------------------------------------------------------------
module rrbmc_ctrl
   import rrbmc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [BYTE_W-1:0]     req_rx_byte,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output logic                  mem_wr_en,
   output logic [IDX_W-1:0]      mem_wr_addr,
   output logic [BYTE_W-1:0]     mem_wr_data,
   output logic [IDX_W-1:0]      mem_rd_addr,
   input  logic [BYTE_W-1:0]     mem_rd_data,
   output rsp_type               rsp
);

   typedef enum logic {
      ST_IDLE,
      ST_POP
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  msg_ff, msg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              drain_ff, drain_in;
   logic              term_en_ff, term_en_in;
   logic [BYTE_W-1:0] term_char_ff, term_char_in;
   rsp_type           rsp_ff, rsp_in;

   logic [IDX_W-1:0]  rd_next;
   logic              accept;
   logic              full;

   assign accept  = start && (state_ff == ST_IDLE);
   assign rd_next = next_index(rd_idx_ff);
   assign full    = (fill_ff == FULL_FILL);

   assign mem_wr_addr = wr_idx_ff;
   assign mem_wr_data = req_rx_byte;
   assign mem_rd_addr = (state_ff == ST_POP) ? rd_next : rd_idx_ff;

   always_comb begin
      state_in     = state_ff;
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      fill_in      = fill_ff;
      msg_in       = msg_ff;
      cnt_in       = cnt_ff;
      drain_in     = drain_ff;
      term_en_in   = term_en_ff;
      term_char_in = term_char_ff;
      mem_wr_en    = 1'b0;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_TERM_ENABLE: term_en_in   = csr_write_data[0];
            CSR_TERM_CHAR:   term_char_in = csr_write_data[BYTE_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op_type'(req_operation))
                  OP_RECEIVE: begin
                     if (!full) begin
                        mem_wr_en = 1'b1;
                        wr_idx_in = next_index(wr_idx_ff);
                        fill_in   = fill_ff + IDX_W'(1);
                        if (term_en_ff && (req_rx_byte == term_char_ff)
                            && (msg_ff != COUNT_MAX)) begin
                           msg_in = msg_ff + CNT_W'(1);
                        end
                     end
                  end
                  OP_READ_BYTE: begin
                     if (fill_ff != '0) begin
                        state_in = ST_POP;
                        drain_in = 1'b0;
                     end
                  end
                  OP_READ_MESSAGE: begin
                     if ((msg_ff == '0) || (fill_ff == '0)) begin
                        if (msg_ff != '0) begin
                           msg_in = msg_ff - CNT_W'(1);
                        end
                     end else begin
                        state_in = ST_POP;
                        drain_in = 1'b1;
                        cnt_in   = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_POP: begin
            rd_idx_in = rd_next;
            fill_in   = fill_ff - IDX_W'(1);
            state_in  = ST_IDLE;
            if (drain_ff) begin
               if ((mem_rd_data == term_char_ff) || (fill_ff == IDX_W'(1))) begin
                  msg_in = msg_ff - CNT_W'(1);
               end else if (cnt_ff != DRAIN_END) begin
                  state_in = ST_POP;
                  cnt_in   = cnt_ff + CNT_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result of the cycle, registered for the next one
   always_comb begin
      rsp_in                    = '0;
      rsp_in.last               = 1'b1;
      rsp_in.bytes_available    = fill_report(fill_in);
      rsp_in.messages_available = msg_in;
      case (state_ff)
         ST_IDLE: begin
            rsp_in.strobe = accept;
            if (accept && (op_type'(req_operation) == OP_RECEIVE) && full) begin
               rsp_in.overflow = 1'b1;
            end
            if (state_in == ST_POP) begin
               rsp_in.strobe = 1'b0;
            end
         end
         ST_POP: begin
            rsp_in.strobe     = 1'b1;
            rsp_in.data_byte  = mem_rd_data;
            rsp_in.data_valid = 1'b1;
            rsp_in.last       = (state_in == ST_IDLE);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      wr_idx_ff    <= wr_idx_in;
      rd_idx_ff    <= rd_idx_in;
      fill_ff      <= fill_in;
      msg_ff       <= msg_in;
      cnt_ff       <= cnt_in;
      drain_ff     <= drain_in;
      term_en_ff   <= term_en_in;
      term_char_ff <= term_char_in;
      state_ff     <= state_in;
      rsp_ff       <= rsp_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         wr_idx_ff     <= '0;
         rd_idx_ff     <= '0;
         fill_ff       <= '0;
         msg_ff        <= '0;
         cnt_ff        <= '0;
         drain_ff      <= 1'b0;
         term_en_ff    <= 1'b0;
         term_char_ff  <= '0;
         rsp_ff        <= '0;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp  = rsp_ff;

endmodule

/* hw/rtl/rx_ring_buffer_message_count.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_ring_buffer_message_count
// Receive ring buffer for a serial port with counting of terminated messages.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Receive and status
// commands give their single result in the next cycle and the block is ready
// again at once. A byte read gives its result through the pop state and the
// result register, since the byte store is a RAM with a registered read; a
// message drain gives one byte per cycle and keeps busy high while it pops.
// Results are shown for one cycle under rsp_strobe and cannot be held off,
// so the receiver must take every one.
// The byte store needs no clearing after reset.
module rx_ring_buffer_message_count
   import rrbmc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [BYTE_W-1:0]     req_rx_byte,
   output logic                  rsp_strobe,
   output logic [BYTE_W-1:0]     rsp_data_byte,
   output logic                  rsp_data_valid,
   output logic                  rsp_last,
   output logic [CNT_W-1:0]      rsp_bytes_available,
   output logic [CNT_W-1:0]      rsp_messages_available,
   output logic                  rsp_overflow,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   logic              mem_wr_en;
   logic [IDX_W-1:0]  mem_wr_addr;
   logic [BYTE_W-1:0] mem_wr_data;
   logic [IDX_W-1:0]  mem_rd_addr;
   logic [BYTE_W-1:0] mem_rd_data;
   rsp_type           rsp;

   rrbmc_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_rx_byte      (req_rx_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data),
      .rsp              (rsp)
   );

   rrbmc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_byte_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_strobe             = rsp.strobe;
   assign rsp_data_byte          = rsp.data_byte;
   assign rsp_data_valid         = rsp.data_valid;
   assign rsp_last               = rsp.last;
   assign rsp_bytes_available    = rsp.bytes_available;
   assign rsp_messages_available = rsp.messages_available;
   assign rsp_overflow           = rsp.overflow;

endmodule

/* hw/rtl/rrbmc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrbmc_checker
// Port-level checks on the receive ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
module rrbmc_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_data_valid,
   input logic       rsp_last,
   input logic       rsp_overflow
);

   // out of reset nothing is pending
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("result or busy after reset");

   // a command taken while idle gives no popped or partial result next cycle
   a_accept_single: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (!rsp_strobe || (rsp_last && !rsp_data_valid)))
      else $error("unexpected result after command transfer");

   // a drain in progress keeps the block busy
   a_drain_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> (busy && rsp_data_valid))
      else $error("partial drain result while idle");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data_valid) |-> (rsp_data_byte == 8'd0))
      else $error("data byte not zero without valid data");

   a_overflow_status: assert property (@(posedge clock) disable iff (reset)
      rsp_overflow |-> (rsp_strobe && rsp_last && !rsp_data_valid))
      else $error("overflow on a popped result");

endmodule

bind rx_ring_buffer_message_count rrbmc_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_data_byte  (rsp_data_byte),
   .rsp_data_valid (rsp_data_valid),
   .rsp_last       (rsp_last),
   .rsp_overflow   (rsp_overflow)
);
